// ===== sv/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types and fixed field widths for the top-k score tracker.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int RANK_W = 4;
  localparam int SLOT_W = 4;
  localparam int FILL_W = 5;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;      // latch the incoming item and clear the pass state
    logic freed_rd;   // read the lowest held rank
    logic freed_cap;  // take the slot of the lowest held rank
    logic rd;         // read the rank under the pass counter
    logic ev;         // evaluate the rank read in the previous cycle
    logic tail;       // write the entry one past the held ranks
    logic finish;     // load the result register and commit the count
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;       // held count has reached the effective capacity
    logic k_lt_n;     // pass counter is still inside the held ranks
    logic out_free;   // result register can take a new result
  } ctl_stat_t;

endpackage

// ===== sv/tks_ctrl.sv =====
// ----------------------------------------------------------------------------
// tks_ctrl
// Sequencer for one insertion pass over the ranked list.
// ----------------------------------------------------------------------------
module tks_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tks_pkg::ctl_stat_t stat,
  output tks_pkg::ctl_cmd_t  cmd
);
  import tks_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FRD,
    S_FWT,
    S_STEP,
    S_EV,
    S_TAIL,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          // A full list first needs the slot of its lowest entry.
          state_nxt = stat.full ? S_FRD : S_STEP;
        end
      end
      S_FRD: begin
        cmd.freed_rd = 1'b1;
        state_nxt    = S_FWT;
      end
      S_FWT: begin
        cmd.freed_cap = 1'b1;
        state_nxt     = S_STEP;
      end
      S_STEP: begin
        if (stat.k_lt_n) begin
          cmd.rd    = 1'b1;
          state_nxt = S_EV;
        end else if (!stat.full) begin
          state_nxt = S_TAIL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_EV: begin
        cmd.ev    = 1'b1;
        state_nxt = S_STEP;
      end
      S_TAIL: begin
        cmd.tail  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/tks_datapath.sv =====
// ----------------------------------------------------------------------------
// tks_datapath
// Ranked list memory, pass registers, capacity register and result register.
// ----------------------------------------------------------------------------
module tks_datapath #(
  parameter int MAX_ENTRIES = 16,
  parameter int SCORE_BITS  = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [SCORE_BITS-1:0]       in_score,
  input  logic                               cfg_we,
  input  logic [tks_pkg::CAP_W-1:0]          cfg_wdata,
  input  tks_pkg::ctl_cmd_t                  cmd,
  output tks_pkg::ctl_stat_t                 stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_accepted,
  output logic [tks_pkg::RANK_W-1:0]         out_rank,
  output logic [tks_pkg::SLOT_W-1:0]         out_slot,
  output logic                               out_evicted,
  output logic [tks_pkg::FILL_W-1:0]         out_fill_count
);
  import tks_pkg::*;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int WORD_W = SCORE_BITS + IDX_W;

  // Each word holds a score and its slot. Ranks at or above the held count
  // are never read, so the memory needs no initialization.
  logic [WORD_W-1:0] mem [MAX_ENTRIES];

  logic [CAP_W-1:0]             cap_r;
  logic [CNT_W-1:0]             count_r;
  logic signed [SCORE_BITS-1:0] key_r;
  logic [CNT_W-1:0]             k_r;
  logic [WORD_W-1:0]            carry_r;
  logic                         ins_r;
  logic [IDX_W-1:0]             place_r;
  logic [IDX_W-1:0]             new_slot_r;
  logic [WORD_W-1:0]            rd_data_r;

  logic                         out_valid_r;
  logic                         out_accepted_r;
  logic [RANK_W-1:0]            out_rank_r;
  logic [SLOT_W-1:0]            out_slot_r;
  logic                         out_evicted_r;
  logic [FILL_W-1:0]            out_fill_r;

  logic [CMP_W-1:0]             cap_ext;
  logic [CMP_W-1:0]             max_ext;
  logic [CMP_W-1:0]             eff_cap;
  logic [CMP_W-1:0]             count_ext;
  logic                         full;
  logic [CNT_W-1:0]             count_m1;
  logic [IDX_W-1:0]             rd_addr;
  logic                         rd_en;
  logic signed [SCORE_BITS-1:0] d_score;
  logic                         d_gt;
  logic [WORD_W-1:0]            new_word;
  logic                         wr_en;
  logic [WORD_W-1:0]            wr_data;
  logic [CNT_W-1:0]             fill_now;
  logic [IDX_W+RANK_W-1:0]      rank_ext;
  logic [IDX_W+SLOT_W-1:0]      slot_ext;
  logic [CNT_W+FILL_W-1:0]      fill_ext;

  // Capacity of zero acts as one, anything above the depth as the depth.
  assign cap_ext   = CMP_W'(cap_r);
  assign max_ext   = CMP_W'(MAX_ENTRIES);
  assign count_ext = CMP_W'(count_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > max_ext) begin
      eff_cap = max_ext;
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign full = (count_ext >= eff_cap);

  assign count_m1 = count_r - CNT_W'(1);
  assign rd_addr  = cmd.freed_rd ? count_m1[IDX_W-1:0] : k_r[IDX_W-1:0];
  assign rd_en    = cmd.freed_rd | cmd.rd;

  assign d_score  = rd_data_r[WORD_W-1:IDX_W];
  assign d_gt     = (d_score > key_r);
  assign new_word = {key_r, new_slot_r};

  // Once the new entry is in, every later rank takes the entry above it.
  assign wr_en   = (cmd.ev && (ins_r || !d_gt)) || cmd.tail;
  assign wr_data = ins_r ? carry_r : new_word;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[k_r[IDX_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_r <= 1'b0;
    end else if (cmd.start) begin
      ins_r <= 1'b0;
    end else if ((cmd.ev && !d_gt) || cmd.tail) begin
      ins_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r      <= in_score;
      k_r        <= '0;
      new_slot_r <= IDX_W'(count_r);
    end
    if (cmd.freed_cap) begin
      new_slot_r <= rd_data_r[IDX_W-1:0];
    end
    if (cmd.ev) begin
      k_r <= k_r + CNT_W'(1);
      if (wr_en) begin
        carry_r <= rd_data_r;
      end
      if (!ins_r && !d_gt) begin
        place_r <= k_r[IDX_W-1:0];
      end
    end
    if (cmd.tail && !ins_r) begin
      place_r <= k_r[IDX_W-1:0];
    end
  end

  assign fill_now = full ? count_r : count_r + CNT_W'(1);
  assign rank_ext = {{RANK_W{1'b0}}, place_r};
  assign slot_ext = {{SLOT_W{1'b0}}, new_slot_r};
  assign fill_ext = {{FILL_W{1'b0}}, fill_now};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (!full) begin
          count_r <= fill_now;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_accepted_r <= ins_r;
      out_rank_r     <= ins_r ? rank_ext[RANK_W-1:0] : '0;
      out_slot_r     <= ins_r ? slot_ext[SLOT_W-1:0] : '0;
      out_evicted_r  <= full && ins_r;
      out_fill_r     <= fill_ext[FILL_W-1:0];
    end
  end

  assign stat.full     = full;
  assign stat.k_lt_n   = (k_r < count_r);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_rank       = out_rank_r;
  assign out_slot       = out_slot_r;
  assign out_evicted    = out_evicted_r;
  assign out_fill_count = out_fill_r;

endmodule

// ===== sv/top_k_score_tracker.sv =====
// ----------------------------------------------------------------------------
// top_k_score_tracker
// Keeps the best scores seen so far in descending order, with a slot per rank.
// ----------------------------------------------------------------------------
// One item is processed at a time. A full list first reads the slot of its
// lowest entry; then the insertion pass reads and rewrites the ranked list
// memory one rank at a time (read, then compare and write). The result is
// loaded into the output register only once a result still held by
// out_ready has been taken. A new item is taken as soon as the result
// register is loaded, even while that result still waits on out_ready.
// The user must write the capacity register through cfg_we and cfg_wdata
// only while the block is idle; the block itself does not enforce this.
module top_k_score_tracker #(
  parameter int MAX_ENTRIES = 16,
  parameter int SCORE_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SCORE_BITS-1:0]  in_score,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic [tks_pkg::RANK_W-1:0]    out_rank,
  output logic [tks_pkg::SLOT_W-1:0]    out_slot,
  output logic                          out_evicted,
  output logic [tks_pkg::FILL_W-1:0]    out_fill_count,
  input  logic                          cfg_we,
  input  logic [tks_pkg::CAP_W-1:0]     cfg_wdata
);
  import tks_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  tks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tks_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SCORE_BITS  (SCORE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_score       (in_score),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_rank       (out_rank),
    .out_slot       (out_slot),
    .out_evicted    (out_evicted),
    .out_fill_count (out_fill_count)
  );

endmodule

// ===== sv/tks_checker.sv =====
// ----------------------------------------------------------------------------
// tks_checker
// Port-level checks for the top-k score tracker, bound to the top level.
// ----------------------------------------------------------------------------
module tks_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_accepted,
  input logic [tks_pkg::RANK_W-1:0] out_rank,
  input logic [tks_pkg::SLOT_W-1:0] out_slot,
  input logic                       out_evicted,
  input logic [tks_pkg::FILL_W-1:0] out_fill_count
);

  // A rejected item reports no rank, no slot and no eviction.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_rank == '0 && out_slot == '0 && !out_evicted)
    else $error("rejected item carries nonzero rank, slot or evicted");

  // Only an accepted item can evict an entry.
  a_evict_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_accepted)
    else $error("eviction reported without acceptance");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an item was taken");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_rank)
      && $stable(out_fill_count))
    else $error("stalled result changed");

endmodule

bind top_k_score_tracker tks_checker u_tks_checker (.*);

// ===== bench/top_k_score_tracker_test.sv =====
// ----------------------------------------------------------------------------
// top_k_score_tracker_test
// Self-checking bench for the top-k score tracker. Both handshakes see random
// gaps and stalls. A short table of directed items and capacity writes is
// followed by random phases at several capacities. Each result is checked
// against its row's placement if given, else an in-bench ranked-list model.
// ----------------------------------------------------------------------------
module top_k_score_tracker_test;
  import tks_pkg::*;

  localparam int SCORE_W      = 32;
  localparam int MAX_HELD     = 16;
  localparam int PHASE_ITEMS  = 125;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_LIMIT = 10;

  typedef logic signed [SCORE_W-1:0] score_t;

  typedef struct packed {
    logic              accepted;
    logic [RANK_W-1:0] rank;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [FILL_W-1:0] fill;
  } placement_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    score_t           score;
    logic [CAP_W-1:0] cap;
    logic             check;
    placement_t       want;
  } dir_row_t;

  localparam placement_t NO_WANT = '0;

  localparam dir_row_t DIRECTED [25] = '{
    '{ROW_ITEM, 32'h0000_0000, 5'd0,  1'b1, {1'b1, 4'd0, 4'd0, 1'b0, 5'd1}},
    '{ROW_ITEM, 32'h7FFF_FFFF, 5'd0,  1'b1, {1'b1, 4'd0, 4'd1, 1'b0, 5'd2}},
    '{ROW_ITEM, 32'h8000_0000, 5'd0,  1'b1, {1'b1, 4'd2, 4'd2, 1'b0, 5'd3}},
    '{ROW_CFG,  32'h0000_0000, 5'd2,  1'b0, NO_WANT},
    '{ROW_ITEM, 32'h0000_0001, 5'd0,  1'b1, {1'b1, 4'd1, 4'd2, 1'b1, 5'd3}},
    '{ROW_ITEM, 32'h8000_0000, 5'd0,  1'b1, {1'b0, 4'd0, 4'd0, 1'b0, 5'd3}},
    '{ROW_ITEM, 32'hFFFF_FFFF, 5'd0,  1'b1, {1'b0, 4'd0, 4'd0, 1'b0, 5'd3}},
    '{ROW_ITEM, 32'h0000_0000, 5'd0,  1'b1, {1'b1, 4'd2, 4'd0, 1'b1, 5'd3}},
    '{ROW_CFG,  32'h0000_0000, 5'd0,  1'b0, NO_WANT},
    '{ROW_ITEM, 32'h7FFF_FFFF, 5'd0,  1'b0, NO_WANT},
    '{ROW_ITEM, 32'h8000_0000, 5'd0,  1'b0, NO_WANT},
    '{ROW_CFG,  32'h0000_0000, 5'd31, 1'b0, NO_WANT},
    '{ROW_ITEM, 32'h0001_0000, 5'd0,  1'b0, NO_WANT},
    '{ROW_ITEM, 32'h8000_0001, 5'd0,  1'b0, NO_WANT},
    '{ROW_ITEM, 32'h7FFF_FFFE, 5'd0,  1'b0, NO_WANT},
    '{ROW_ITEM, 32'hFFFF_0000, 5'd0,  1'b0, NO_WANT},
    '{ROW_ITEM, 32'h5555_5555, 5'd0,  1'b0, NO_WANT},
    '{ROW_ITEM, 32'hAAAA_AAAA, 5'd0,  1'b0, NO_WANT},
    '{ROW_CFG,  32'h0000_0000, 5'd1,  1'b0, NO_WANT},
    '{ROW_ITEM, 32'h7FFF_FFFF, 5'd0,  1'b0, NO_WANT},
    '{ROW_ITEM, 32'h8000_0000, 5'd0,  1'b0, NO_WANT},
    '{ROW_CFG,  32'h0000_0000, 5'd16, 1'b0, NO_WANT},
    '{ROW_ITEM, 32'h0000_0000, 5'd0,  1'b0, NO_WANT},
    '{ROW_ITEM, 32'h0000_0000, 5'd0,  1'b0, NO_WANT},
    '{ROW_ITEM, 32'h7FFF_FFFF, 5'd0,  1'b0, NO_WANT}
  };

  localparam logic [CAP_W-1:0] PHASE_CAPS [10] = '{
    5'd16, 5'd1, 5'd0, 5'd5, 5'd31, 5'd3, 5'd16, 5'd2, 5'd9, 5'd16
  };

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  score_t           in_score       = '0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic             out_accepted;
  logic [RANK_W-1:0] out_rank;
  logic [SLOT_W-1:0] out_slot;
  logic             out_evicted;
  logic [FILL_W-1:0] out_fill_count;
  logic             cfg_we         = 1'b0;
  logic [CAP_W-1:0] cfg_wdata      = '0;

  // Model of the ranked list.
  score_t           list_score [MAX_HELD];
  logic [SLOT_W-1:0] list_slot [MAX_HELD];
  int unsigned      list_count;
  logic [CAP_W-1:0] cap_setting;

  placement_t       owed_placements [$];
  int               error_count  = 0;
  int               mismatches   = 0;
  int               results_seen = 0;
  int               cycle_count  = 0;
  bit               steady       = 1'b0;
  bit               held_off     = 1'b0;

  top_k_score_tracker #(
    .MAX_ENTRIES (MAX_HELD),
    .SCORE_BITS  (SCORE_W)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_score       (in_score),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_rank       (out_rank),
    .out_slot       (out_slot),
    .out_evicted    (out_evicted),
    .out_fill_count (out_fill_count),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned usable_capacity();
    int unsigned c;
    c = 32'(cap_setting);
    if (c < 1) c = 1;
    if (c > MAX_HELD) c = MAX_HELD;
    return c;
  endfunction

  // Inserts a score into the model list and returns the placement it earns.
  function automatic placement_t place_score(input score_t s);
    placement_t  p;
    int unsigned n;
    int unsigned pos;
    logic [SLOT_W-1:0] freed;
    p   = '0;
    n   = list_count;
    pos = 0;
    while (pos < n && list_score[pos] > s) pos++;
    if (n < usable_capacity()) begin
      for (int k = n; k > pos; k--) begin
        list_score[k] = list_score[k-1];
        list_slot[k]  = list_slot[k-1];
      end
      list_score[pos] = s;
      list_slot[pos]  = SLOT_W'(n);
      p.accepted = 1'b1;
      p.rank     = RANK_W'(pos);
      p.slot     = SLOT_W'(n);
      list_count = n + 1;
    end else if (pos < n) begin
      // Full list: the lowest held rank drops out and hands over its slot.
      freed = list_slot[n-1];
      for (int k = n - 1; k > pos; k--) begin
        list_score[k] = list_score[k-1];
        list_slot[k]  = list_slot[k-1];
      end
      list_score[pos] = s;
      list_slot[pos]  = freed;
      p.accepted = 1'b1;
      p.rank     = RANK_W'(pos);
      p.slot     = freed;
      p.evicted  = 1'b1;
    end
    p.fill = FILL_W'(list_count);
    return p;
  endfunction

  function automatic int pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Scores are drawn so that ties, near-minimum entries and evictions are common.
  function automatic score_t pick_score();
    score_t s;
    s = score_t'($urandom);
    case ($urandom_range(0, 9))
      3, 4: s = score_t'($signed($urandom_range(0, 16)) - 8);
      5, 6: if (list_count > 0)
              s = list_score[list_count-1] + score_t'($signed($urandom_range(0, 4)) - 2);
      7:    s = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      8:    if (list_count > 0)
              s = list_score[$urandom_range(0, list_count - 1)];
      9:    s = score_t'({2'b01, 30'($urandom)});
      default: ;
    endcase
    return s;
  endfunction

  // Offers one score and returns at the edge where it is taken.
  task automatic send_score(input score_t s, input bit check, input placement_t want);
    int gap;
    placement_t p;
    gap = steady ? 0 : pick_delay();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_score <= s;
    do @(posedge clk); while (!in_ready);
    p = place_score(s);
    owed_placements.push_back(check ? want : p);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    in_valid <= 1'b0;
    while (owed_placements.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cap_setting = value;
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    placement_t got;
    placement_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      got = {out_accepted, out_rank, out_slot, out_evicted, out_fill_count};
      if (owed_placements.size() == 0) begin
        error_count <= error_count + 1;
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result item: accepted=%0d rank=%0d slot=%0d evicted=%0d fill=%0d",
                   got.accepted, got.rank, got.slot, got.evicted, got.fill);
        mismatches <= mismatches + 1;
      end else begin
        want = owed_placements.pop_front();
        if (got !== want) begin
          error_count <= error_count + 1;
          if (mismatches < REPORT_LIMIT)
            $display("result mismatch: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                     want.accepted, want.rank, want.slot, want.evicted, want.fill,
                     got.accepted, got.rank, got.slot, got.evicted, got.fill);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off that backs up the input.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && results_seen >= HOLD_AT) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (pick_delay() + 1) @(posedge clk);
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_HELD; i++) begin
      list_score[i] = '0;
      list_slot[i]  = SLOT_W'(i);
    end
    list_count  = 0;
    cap_setting = CAP_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG)
        write_capacity(DIRECTED[i].cap);
      else
        send_score(DIRECTED[i].score, DIRECTED[i].check, DIRECTED[i].want);
    end

    foreach (PHASE_CAPS[ph]) begin
      write_capacity(PHASE_CAPS[ph]);
      steady = (ph == 3);
      repeat (PHASE_ITEMS) send_score(pick_score(), 1'b0, NO_WANT);
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (owed_placements.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (error_count == 0 && owed_placements.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tks_pkg.sv
sv/tks_ctrl.sv
sv/tks_datapath.sv
sv/top_k_score_tracker.sv
sv/tks_checker.sv
bench/top_k_score_tracker_test.sv
